@@ src/per_cpu_ring_object_pool_assert.svh @@
// assertion macros for the per-cpu ring object pool
`ifndef PER_CPU_RING_OBJECT_POOL_ASSERT_SVH
`define PER_CPU_RING_OBJECT_POOL_ASSERT_SVH

`ifndef SYNTH

`define PCROP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcrop assertion failed");

`define PCROP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcrop assertion failed");

`else

`define PCROP_ASSERT_NOW(name, clk, rst, ante, cons)

`define PCROP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ src/pcrop_pkg.sv @@
// types and constants shared by the per-cpu ring object pool
package pcrop_pkg;

   localparam int HANDLE_W    = 8;
   localparam int REQ_IDX_W   = 3;
   localparam int TOTAL_W     = 9;
   localparam int MASK_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_HANDLES = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_OBJECTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK   = 2'd1;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 9'd64;
   localparam logic [MASK_W-1:0]  MASK_RESET  = 8'd255;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_EMPTY       = 2'd1;
   localparam logic [1:0] ST_OVERFLOW    = 2'd2;
   localparam logic [1:0] ST_NOT_ENABLED = 2'd3;

   typedef struct packed {
      logic                 kind;
      logic [REQ_IDX_W-1:0] requester;
      logic [HANDLE_W-1:0]  handle_in;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [HANDLE_W-1:0]  handle_out;
      logic [REQ_IDX_W-1:0] source_ring;
   } rsp_type;

endpackage

@@ src/pcrop_ring_mem.sv @@
// handle store for all rings, one write port and one read port, registered read
module pcrop_ring_mem #(
   parameter int WORDS  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [pcrop_pkg::HANDLE_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [pcrop_pkg::HANDLE_W-1:0] rd_data
);
   import pcrop_pkg::*;

   logic [HANDLE_W-1:0] mem_ff [WORDS];
   logic [HANDLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/per_cpu_ring_object_pool.sv @@
// per-cpu ring object pool: sequencer, ring pointers and result register
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type (kind, requester, handle_in)
//   rsp      out        rsp_valid/rsp_stall  rsp_type (status, handle_out, source_ring)
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// push: accepted, then one memory write once the output register is free; denied request: accepted, then answered
// pop: one ring checked per cycle, then one memory read; the answer waits while the output register is held
// after reset or a write to the total or mask register the pool reloads before taking a transaction:
//   repeated subtraction splits the total over the enabled rings, then the handles are dealt ring by ring
// a transaction can be taken while the previous result still waits in the output register
module per_cpu_ring_object_pool #(
   parameter int NUM_REQUESTERS = 8,
   parameter int RING_DEPTH     = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pcrop_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pcrop_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pcrop_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcrop_pkg::TOTAL_W-1:0]   csr_wdata
);
   import pcrop_pkg::*;

   `include "per_cpu_ring_object_pool_assert.svh"

   localparam int RW     = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int PTR_W  = $clog2(2 * RING_DEPTH);
   localparam int OCC_W  = PTR_W + 1;
   localparam int WORDS  = NUM_REQUESTERS * RING_DEPTH;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SEEN_W = 4;

   localparam logic [2:0] S_START = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_DEAL  = 3'd2;
   localparam logic [2:0] S_IDLE  = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;
   localparam logic [2:0] S_SCAN  = 3'd5;
   localparam logic [2:0] S_READ  = 3'd6;
   localparam logic [2:0] S_DENY  = 3'd7;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (32'(p) == 2 * RING_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
      return SLOT_W'((32'(p) >= RING_DEPTH) ? 32'(p) - RING_DEPTH : 32'(p));
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [RW-1:0]       cur_ff, cur_in;
   logic [RW-1:0]       cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]  quot_ff, quot_in;
   logic [TOTAL_W-1:0]  rem_ff, rem_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [TOTAL_W-1:0]  deal_i_ff, deal_i_in;
   logic [TOTAL_W-1:0]  hctr_ff, hctr_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic [PTR_W-1:0]    head_ff [NUM_REQUESTERS];
   logic [PTR_W-1:0]    head_in [NUM_REQUESTERS];
   logic [PTR_W-1:0]    tail_ff [NUM_REQUESTERS];
   logic [PTR_W-1:0]    tail_in [NUM_REQUESTERS];
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [NUM_REQUESTERS-1:0] en_vec;
   logic [SEEN_W-1:0]         n_enabled;
   logic                      req_en;
   logic                      csr_we;
   logic                      out_free;
   logic                      produce;
   rsp_type                   rsp_next;
   logic [PTR_W-1:0]          cur_head;
   logic [PTR_W-1:0]          cur_tail;
   logic [OCC_W-1:0]          occ;
   logic [TOTAL_W-1:0]        share;
   logic                      mem_wr_en;
   logic [ADDR_W-1:0]         mem_wr_addr;
   logic [HANDLE_W-1:0]       mem_wr_data;
   logic                      mem_rd_en;
   logic [ADDR_W-1:0]         mem_rd_addr;
   logic [HANDLE_W-1:0]       mem_rd_data;

   pcrop_ring_mem #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      for (int k = 0; k < NUM_REQUESTERS; k++) begin
         en_vec[k] = (k < MASK_W) && mask_ff[k % MASK_W];
      end
   end

   assign n_enabled = SEEN_W'($countones(en_vec));
   assign req_en    = mask_ff[req_data.requester] && (32'(req_data.requester) < NUM_REQUESTERS);
   assign csr_we    = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_head  = head_ff[cur_ff];
   assign cur_tail  = tail_ff[cur_ff];
   assign occ       = (cur_tail >= cur_head)
                      ? OCC_W'(cur_tail) - OCC_W'(cur_head)
                      : OCC_W'(cur_tail) + OCC_W'(2 * RING_DEPTH) - OCC_W'(cur_head);
   assign share     = quot_ff + TOTAL_W'(TOTAL_W'(seen_ff) < rem_ff);

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      seen_in     = seen_ff;
      deal_i_in   = deal_i_ff;
      hctr_in     = hctr_ff;
      total_in    = total_ff;
      mask_in     = mask_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      handle_in   = handle_ff;
      produce     = 1'b0;
      rsp_next    = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_START: begin
            rem_in    = (total_ff > TOTAL_W'(MAX_HANDLES)) ? TOTAL_W'(MAX_HANDLES) : total_ff;
            quot_in   = '0;
            cur_in    = '0;
            deal_i_in = '0;
            seen_in   = '0;
            hctr_in   = '0;
            for (int k = 0; k < NUM_REQUESTERS; k++) begin
               head_in[k] = '0;
               tail_in[k] = '0;
            end
            state_in  = (n_enabled == '0) ? S_IDLE : S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= TOTAL_W'(n_enabled)) begin
               rem_in  = rem_ff - TOTAL_W'(n_enabled);
               quot_in = quot_ff + 1'b1;
            end else begin
               state_in = S_DEAL;
            end
         end
         S_DEAL: begin
            if (en_vec[cur_ff] && (deal_i_ff < share)) begin
               if (32'(deal_i_ff) < RING_DEPTH) begin
                  mem_wr_en       = 1'b1;
                  mem_wr_addr     = ADDR_W'(32'(cur_ff) * RING_DEPTH + 32'(deal_i_ff));
                  mem_wr_data     = hctr_ff[HANDLE_W-1:0];
                  tail_in[cur_ff] = PTR_W'(32'(deal_i_ff) + 1);
               end
               hctr_in   = hctr_ff + 1'b1;
               deal_i_in = deal_i_ff + 1'b1;
            end else begin
               deal_i_in = '0;
               if (en_vec[cur_ff]) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (32'(cur_ff) == NUM_REQUESTERS - 1) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in = cur_ff + 1'b1;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               handle_in = req_data.handle_in;
               cur_in    = RW'(req_data.requester);
               cnt_in    = '0;
               if (!req_en) begin
                  state_in = S_DENY;
               end else if (req_data.kind == KIND_PUSH) begin
                  state_in = S_PUSH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_PUSH: begin
            if (out_free) begin
               produce              = 1'b1;
               rsp_next.source_ring = REQ_IDX_W'(cur_ff);
               if (32'(occ) >= RING_DEPTH) begin
                  rsp_next.status = ST_OVERFLOW;
               end else begin
                  rsp_next.status = ST_OK;
                  mem_wr_en       = 1'b1;
                  mem_wr_addr     = ADDR_W'(32'(cur_ff) * RING_DEPTH + 32'(ptr_slot(cur_tail)));
                  mem_wr_data     = handle_ff;
                  tail_in[cur_ff] = ptr_inc(cur_tail);
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (en_vec[cur_ff] && (cur_head != cur_tail)) begin
               mem_rd_en       = 1'b1;
               mem_rd_addr     = ADDR_W'(32'(cur_ff) * RING_DEPTH + 32'(ptr_slot(cur_head)));
               head_in[cur_ff] = ptr_inc(cur_head);
               state_in        = S_READ;
            end else if (32'(cnt_ff) == NUM_REQUESTERS - 1) begin
               if (out_free) begin
                  produce         = 1'b1;
                  rsp_next.status = ST_EMPTY;
                  state_in        = S_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
               cur_in = (32'(cur_ff) == NUM_REQUESTERS - 1) ? '0 : cur_ff + 1'b1;
            end
         end
         S_READ: begin
            if (out_free) begin
               produce              = 1'b1;
               rsp_next.status      = ST_OK;
               rsp_next.handle_out  = mem_rd_data;
               rsp_next.source_ring = REQ_IDX_W'(cur_ff);
               state_in             = S_IDLE;
            end
         end
         S_DENY: begin
            if (out_free) begin
               produce         = 1'b1;
               rsp_next.status = ST_NOT_ENABLED;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_START;
         end
      endcase

      if (csr_we) begin
         if (csr_index == CSR_TOTAL_OBJECTS) begin
            total_in = csr_wdata;
            state_in = S_START;
         end else if (csr_index == CSR_ENABLE_MASK) begin
            mask_in  = csr_wdata[MASK_W-1:0];
            state_in = S_START;
         end
      end

      rsp_in       = produce ? rsp_next : rsp_ff;
      rsp_valid_in = produce ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_START;
         cur_ff       <= '0;
         cnt_ff       <= '0;
         quot_ff      <= '0;
         rem_ff       <= '0;
         seen_ff      <= '0;
         deal_i_ff    <= '0;
         hctr_ff      <= '0;
         total_ff     <= TOTAL_RESET;
         mask_ff      <= MASK_RESET;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_REQUESTERS; k++) begin
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cnt_ff       <= cnt_in;
         quot_ff      <= quot_in;
         rem_ff       <= rem_in;
         seen_ff      <= seen_in;
         deal_i_ff    <= deal_i_in;
         hctr_ff      <= hctr_in;
         total_ff     <= total_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `PCROP_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   `PCROP_ASSERT_NOW(a_push_occ_bound, clock, reset, state_ff == S_PUSH, 32'(occ) <= RING_DEPTH)
   `PCROP_ASSERT_NEXT(a_read_delivers, clock, reset, state_ff == S_READ && out_free, rsp_valid_ff && rsp_ff.status == ST_OK)
   `PCROP_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == S_SCAN, 32'(cnt_ff) < NUM_REQUESTERS)

endmodule

@@ dv/tb.sv @@
// testbench for the per-cpu ring object pool: queued transactions, predicted responses, field checks
module tb;
   import pcrop_pkg::*;

   localparam int RING_COUNT    = 8;
   localparam int RING_SLOTS    = 256;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 5000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TOTAL_W-1:0]   csr_wdata = '0;

   // predicted pool state
   logic [HANDLE_W-1:0] pool_slots [RING_COUNT][RING_SLOTS];
   logic [8:0]          ring_rd_ptr [RING_COUNT];
   logic [8:0]          ring_wr_ptr [RING_COUNT];
   logic [TOTAL_W-1:0]  cfg_total;
   logic [MASK_W-1:0]   cfg_mask;

   req_type req_backlog [$];
   rsp_type awaited_rsp_q [$];
   int      items_queued  = 0;
   int      items_taken   = 0;
   int      fail_count    = 0;
   int      quiet_cycles  = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   bit      req_fired     = 1'b0;
   bit      csr_done      = 1'b0;
   bit      progress;
   rsp_type want_rsp;

   per_cpu_ring_object_pool dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // deal handles 0..total-1 (total capped at MAX_HANDLES) over the enabled rings
   function automatic void reload_pool();
      int total, n, quot, rem, seen, next_h, share, r, i;
      for (r = 0; r < RING_COUNT; r++) begin
         ring_rd_ptr[r] = '0;
         ring_wr_ptr[r] = '0;
      end
      total = (cfg_total > MAX_HANDLES) ? MAX_HANDLES : int'(cfg_total);
      n = $countones(cfg_mask);
      if (n == 0) return;
      quot   = total / n;
      rem    = total % n;
      seen   = 0;
      next_h = 0;
      for (r = 0; r < RING_COUNT; r++) begin
         if (cfg_mask[r]) begin
            share = quot + ((seen < rem) ? 1 : 0);
            seen++;
            for (i = 0; i < share; i++) begin
               if (i < RING_SLOTS) begin
                  pool_slots[r][i] = next_h[7:0];
                  ring_wr_ptr[r]   = ring_wr_ptr[r] + 9'd1;
               end
               next_h++;
            end
         end
      end
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [TOTAL_W-1:0] val);
      if (idx == CSR_TOTAL_OBJECTS)
         cfg_total = val;
      else if (idx == CSR_ENABLE_MASK)
         cfg_mask = val[MASK_W-1:0];
      else
         return;
      reload_pool();
   endfunction

   function automatic rsp_type pool_predict(req_type it);
      rsp_type             o;
      logic [8:0]          fill;
      logic [REQ_IDX_W-1:0] ring;
      int                  k;
      o = '0;
      if (!cfg_mask[it.requester]) begin
         o.status = ST_NOT_ENABLED;
         return o;
      end
      if (it.kind == KIND_PUSH) begin
         o.status      = ST_OK;
         o.source_ring = it.requester;
         fill = ring_wr_ptr[it.requester] - ring_rd_ptr[it.requester];
         if (fill >= 9'd256) begin
            o.status = ST_OVERFLOW;
            return o;
         end
         pool_slots[it.requester][ring_wr_ptr[it.requester][7:0]] = it.handle_in;
         ring_wr_ptr[it.requester] = ring_wr_ptr[it.requester] + 9'd1;
         return o;
      end
      for (k = 0; k < RING_COUNT; k++) begin
         ring = it.requester + k[REQ_IDX_W-1:0];
         if (cfg_mask[ring] && ring_wr_ptr[ring] != ring_rd_ptr[ring]) begin
            o.status      = ST_OK;
            o.handle_out  = pool_slots[ring][ring_rd_ptr[ring][7:0]];
            o.source_ring = ring;
            ring_rd_ptr[ring] = ring_rd_ptr[ring] + 9'd1;
            return o;
         end
      end
      o.status = ST_EMPTY;
      return o;
   endfunction

   function automatic req_type random_item();
      req_type it;
      it.kind      = 1'($urandom_range(1));
      it.handle_in = HANDLE_W'($urandom_range(255));
      it.requester = REQ_IDX_W'($urandom_range(7));
      if (cfg_mask != '0 && $urandom_range(99) < 85)
         while (!cfg_mask[it.requester]) it.requester = REQ_IDX_W'($urandom_range(7));
      return it;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   task automatic send(logic kind, int requester, int handle);
      req_type it;
      it.kind      = kind;
      it.requester = requester[REQ_IDX_W-1:0];
      it.handle_in = handle[HANDLE_W-1:0];
      req_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic queue_random(int count);
      int i;
      for (i = 0; i < count; i++) begin
         req_backlog.push_back(random_item());
         items_queued++;
      end
   endtask

   task automatic wait_pool_idle();
      while (items_taken != items_queued || awaited_rsp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TOTAL_W-1:0] val);
      @(negedge clock);
      csr_done = 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_done);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(logic [TOTAL_W-1:0] total, logic [TOTAL_W-1:0] mask,
                            int s_idle, int r_stall, int count);
      write_csr(CSR_TOTAL_OBJECTS, total);
      write_csr(CSR_ENABLE_MASK, mask);
      send_idle_pct = s_idle;
      rsp_stall_pct = r_stall;
      queue_random(count / 2);
      // sender holds off until the pool has answered everything
      wait_pool_idle();
      queue_random(count - count / 2);
      wait_pool_idle();
   endtask

   // driver
   always @(negedge clock) begin
      if (!req_valid || req_fired) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_fired = 1'b0;
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         progress = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (awaited_rsp_q.size() == 0) begin
               report_mismatch("unexpected response status", rsp_data.status, -1);
            end else begin
               want_rsp = awaited_rsp_q.pop_front();
               if (rsp_data.status !== want_rsp.status)
                  report_mismatch("status", rsp_data.status, want_rsp.status);
               if (rsp_data.handle_out !== want_rsp.handle_out)
                  report_mismatch("handle_out", rsp_data.handle_out, want_rsp.handle_out);
               if (rsp_data.source_ring !== want_rsp.source_ring)
                  report_mismatch("source_ring", rsp_data.source_ring, want_rsp.source_ring);
            end
         end
         if (req_valid && !req_stall) begin
            progress = 1'b1;
            awaited_rsp_q.push_back(pool_predict(req_data));
            items_taken++;
            req_fired = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            apply_csr(csr_index, csr_wdata);
            csr_done = 1'b1;
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      cfg_total = TOTAL_RESET;
      cfg_mask  = MASK_RESET;
      reload_pool();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset configuration: eight handles per ring
      send(KIND_POP, 0, 0);
      send(KIND_POP, 7, 0);
      send(KIND_PUSH, 3, 255);
      send(KIND_PUSH, 5, 0);
      send(KIND_POP, 3, 170);
      wait_pool_idle();

      // single handle, single ring
      write_csr(CSR_TOTAL_OBJECTS, 9'd1);
      write_csr(CSR_ENABLE_MASK, 9'h001);
      send(KIND_POP, 0, 0);
      send(KIND_POP, 0, 0);
      send(KIND_PUSH, 1, 9);
      send(KIND_POP, 6, 0);
      wait_pool_idle();

      // total zero
      write_csr(CSR_TOTAL_OBJECTS, 9'd0);
      send(KIND_POP, 0, 0);
      send(KIND_PUSH, 0, 90);
      send(KIND_POP, 0, 0);
      wait_pool_idle();

      // empty mask
      write_csr(CSR_ENABLE_MASK, 9'h000);
      send(KIND_PUSH, 2, 1);
      send(KIND_POP, 0, 0);
      wait_pool_idle();

      // oversized total into one ring, full ring on push
      write_csr(CSR_TOTAL_OBJECTS, 9'd511);
      write_csr(CSR_ENABLE_MASK, 9'h080);
      send(KIND_PUSH, 7, 1);
      send(KIND_POP, 0, 0);
      send(KIND_POP, 7, 0);
      send(KIND_PUSH, 7, 128);
      wait_pool_idle();

      // search wraps past the top requester
      write_csr(CSR_TOTAL_OBJECTS, 9'd2);
      write_csr(CSR_ENABLE_MASK, 9'h081);
      send(KIND_POP, 7, 0);
      send(KIND_POP, 7, 0);
      send(KIND_POP, 7, 0);
      wait_pool_idle();

      // unknown register indexes leave the pool alone
      write_csr(CSR_SPARE_A, 9'h1FF);
      write_csr(CSR_SPARE_B, 9'd0);
      send(KIND_POP, 0, 0);
      wait_pool_idle();

      run_phase(9'd64, 9'h0FF, 0, 0, 106);
      run_phase(9'd256, 9'h0FF, 57, 0, 106);
      run_phase(9'd1, 9'h001, 0, 57, 106);
      run_phase(9'd256, 9'h101, 32, 32, 106);
      run_phase(9'd511, 9'h080, 0, 0, 106);
      run_phase(TOTAL_W'($urandom_range(511)), TOTAL_W'($urandom_range(511)), 57, 0, 106);
      run_phase(9'd200, 9'h05A, 0, 57, 106);
      run_phase(TOTAL_W'($urandom_range(511)), TOTAL_W'($urandom_range(511)), 32, 32, 108);

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/pcrop_pkg.sv
src/pcrop_ring_mem.sv
src/per_cpu_ring_object_pool.sv
dv/tb.sv
